>>> hw/rtl/mpsm_pkg.sv
`timescale 1ns / 1ps
// package for the multi-pattern stream matcher: item types, codes and defaults
// no dependencies
package mpsm_pkg;

  localparam int PAT_COUNT = 4;
  localparam int PAT_WIDTH = 64;
  localparam int LEN_WIDTH = 4;
  localparam int PROG_WIDTH = 4;
  localparam int TICK_WIDTH = 16;
  localparam int CFG_IDX_WIDTH = 3;

  localparam int NUM_PATTERNS_DEF = 4;
  localparam int MAX_PATTERN_LEN_DEF = 8;

  localparam logic [TICK_WIDTH-1:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_PATTERN_A   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PATTERN_B   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PATTERN_C   = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PATTERN_D   = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PAT_LENGTHS = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TIMEOUT     = 3'd5;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] match_number;
    logic       timed_out;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic step;
  } lane_ctrl_t;

endpackage

>>> hw/rtl/mpsm_lane.sv
`timescale 1ns / 1ps
// one pattern lane: progress register and per-byte compare with restart fallback
// depends on mpsm_pkg
module mpsm_lane
  import mpsm_pkg::*;
#(
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lane_ctrl_t           ctrl,
  input  logic [PAT_WIDTH-1:0] pattern,
  input  logic [LEN_WIDTH-1:0] length,
  input  logic [7:0]           rx_byte,
  output logic                 hit
);

  localparam logic [LEN_WIDTH-1:0] MAX_LEN = LEN_WIDTH'(MAX_PATTERN_LEN);

  logic [PROG_WIDTH-1:0] progress;
  logic [PROG_WIDTH-1:0] progress_next;
  logic [LEN_WIDTH-1:0]  len_eff;
  logic [7:0]            cur_char;
  logic [PROG_WIDTH-1:0] prog_inc;
  logic                  char_match;

  always_comb begin
    len_eff = (length > MAX_LEN) ? MAX_LEN : length;
    cur_char = pattern[8*progress[2:0] +: 8];
    prog_inc = progress + PROG_WIDTH'(1);
    char_match = (progress < len_eff) && (rx_byte == cur_char);
    hit = (len_eff != '0) && char_match && (prog_inc == len_eff);
    progress_next = progress;
    if (len_eff != '0) begin
      if (char_match) begin
        progress_next = prog_inc;
      end else begin
        progress_next = (rx_byte == pattern[7:0]) ? PROG_WIDTH'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      progress <= '0;
    end else if (ctrl.clear) begin
      progress <= '0;
    end else if (ctrl.step) begin
      progress <= progress_next;
    end
  end

endmodule

>>> hw/rtl/multi_pattern_stream_matcher_top.sv
`timescale 1ns / 1ps
// Stream matcher that watches received bytes for up to four configured patterns and ends
// the search on the first completed pattern or on a tick timeout. It takes one item every
// cycle unless a held result stalls it; an item passes an input register and a result
// register. A start item arms the search and clears all progress and the tick count;
// bytes and ticks outside a search, and command 3, give no result. The user must write
// configuration registers via the cfg channel only while idle; it is not enforced.
// depends on mpsm_pkg and mpsm_lane
module multi_pattern_stream_matcher_top
  import mpsm_pkg::*;
#(
  parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_item,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [PAT_WIDTH-1:0]     cfg_data
);

  logic [PAT_WIDTH-1:0]       pattern [PAT_COUNT];
  logic [LEN_WIDTH*PAT_COUNT-1:0] pattern_lengths;
  logic [TICK_WIDTH-1:0]      timeout_ticks;

  logic                  s1_valid;
  in_item_t              s1_item;
  logic                  s1_fire;
  logic                  search_active;
  logic                  search_active_next;
  logic [TICK_WIDTH-1:0] elapsed_ticks;
  logic [TICK_WIDTH-1:0] elapsed_ticks_next;
  logic                  byte_go;
  logic                  tick_go;
  logic                  start_go;
  logic                  tick_expired;
  logic [NUM_PATTERNS-1:0] hit;
  lane_ctrl_t            lane_ctrl;
  logic                  result_valid;
  out_item_t             result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PAT_COUNT; p++) begin
        pattern[p] <= '0;
      end
      pattern_lengths <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN_A:   pattern[0] <= cfg_data;
        REG_PATTERN_B:   pattern[1] <= cfg_data;
        REG_PATTERN_C:   pattern[2] <= cfg_data;
        REG_PATTERN_D:   pattern[3] <= cfg_data;
        REG_PAT_LENGTHS: pattern_lengths <= cfg_data[LEN_WIDTH*PAT_COUNT-1:0];
        REG_TIMEOUT:     timeout_ticks <= cfg_data[TICK_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  assign s1_fire = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_item;
    end
  end

  assign start_go = s1_fire && (s1_item.command == CMD_START);
  assign byte_go = s1_fire && search_active && (s1_item.command == CMD_BYTE);
  assign tick_go = s1_fire && search_active && (s1_item.command == CMD_TICK);

  assign lane_ctrl.clear = start_go;
  assign lane_ctrl.step = byte_go;

  for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_lane
    mpsm_lane #(
      .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .pattern (pattern[p]),
      .length  (pattern_lengths[LEN_WIDTH*p +: LEN_WIDTH]),
      .rx_byte (s1_item.rx_byte),
      .hit     (hit[p])
    );
  end

  always_comb begin
    elapsed_ticks_next = elapsed_ticks;
    if (elapsed_ticks != '1) begin
      elapsed_ticks_next = elapsed_ticks + TICK_WIDTH'(1);
    end
    tick_expired = (elapsed_ticks_next >= timeout_ticks);

    // lowest numbered pattern wins
    result.match_number = '0;
    result.timed_out = 1'b0;
    for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
      if (hit[p]) begin
        result.match_number = 3'(p + 1);
      end
    end
    result_valid = 1'b0;
    if (byte_go && (|hit)) begin
      result_valid = 1'b1;
    end else if (tick_go && tick_expired) begin
      result_valid = 1'b1;
      result.match_number = '0;
      result.timed_out = 1'b1;
    end

    search_active_next = search_active;
    if (start_go) begin
      search_active_next = 1'b1;
    end else if (result_valid) begin
      search_active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_active <= 1'b0;
      elapsed_ticks <= '0;
    end else begin
      search_active <= search_active_next;
      if (start_go) begin
        elapsed_ticks <= '0;
      end else if (tick_go) begin
        elapsed_ticks <= elapsed_ticks_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid) begin
      out_item <= result;
    end
  end

endmodule
